// ===== sv/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and types for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int CW = 16;          // coordinate width
  localparam int DW = CW + 1;      // difference width
  localparam int PW = 2 * DW;      // product width
  localparam int TW = PW + 2;      // dot product width, signed
  localparam int LW = PW;          // squared length width, unsigned
  localparam int NW = 2 * LW;      // numerator width
  localparam int FB = 16;          // fraction bits before the root
  localparam int QW = LW + FB;     // quotient width
  localparam int RW = QW / 2;      // root width
  localparam int FRONT_DEPTH = 6;
  localparam int DEPTH = FRONT_DEPTH + QW + RW;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [LW-1:0] den;
  } div_in_t;

endpackage

// ===== sv/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Vector differences, dot products, clamp selection and the wide numerator.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [psd_pkg::CW-1:0] px,
  input  logic signed [psd_pkg::CW-1:0] py,
  input  logic signed [psd_pkg::CW-1:0] pz,
  input  logic signed [psd_pkg::CW-1:0] ax,
  input  logic signed [psd_pkg::CW-1:0] ay,
  input  logic signed [psd_pkg::CW-1:0] az,
  input  logic signed [psd_pkg::CW-1:0] bx,
  input  logic signed [psd_pkg::CW-1:0] by,
  input  logic signed [psd_pkg::CW-1:0] bz,
  output logic                         out_valid,
  output psd_pkg::div_in_t             dout
);

  localparam int DW = psd_pkg::DW;
  localparam int PW = psd_pkg::PW;
  localparam int TW = psd_pkg::TW;
  localparam int LW = psd_pkg::LW;
  localparam int NW = psd_pkg::NW;
  localparam int HW = LW / 2;

  logic v1, v2, v3, v4, v5, v6;

  // stage 1: differences
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] e [3];
  logic signed [DW-1:0] f [3];

  // stage 2: products
  logic signed [PW-1:0] p_de [3];
  logic signed [PW-1:0] p_ee [3];
  logic signed [PW-1:0] p_dd [3];
  logic signed [PW-1:0] p_ff [3];

  // stage 3: sums
  logic signed [TW-1:0] t;
  logic [LW-1:0] len2, dd, ff;

  // stage 4: clamp and partial products
  logic mid4;
  logic [LW-1:0] base4, len4;
  logic [2*HW-1:0] a_hh, a_hl, a_lh, a_ll, t_hh, t_hl, t_ll;

  // stage 5: full products
  logic mid5;
  logic [LW-1:0] base5, len5;
  logic [NW-1:0] prod_a, prod_t;

  logic [LW-1:0] tu;
  logic t_le0, t_geL;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= DW'(px) - DW'(ax);
      d[1] <= DW'(py) - DW'(ay);
      d[2] <= DW'(pz) - DW'(az);
      e[0] <= DW'(bx) - DW'(ax);
      e[1] <= DW'(by) - DW'(ay);
      e[2] <= DW'(bz) - DW'(az);
      f[0] <= DW'(px) - DW'(bx);
      f[1] <= DW'(py) - DW'(by);
      f[2] <= DW'(pz) - DW'(bz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_de[i] <= d[i] * e[i];
        p_ee[i] <= e[i] * e[i];
        p_dd[i] <= d[i] * d[i];
        p_ff[i] <= f[i] * f[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t    <= TW'(p_de[0]) + TW'(p_de[1]) + TW'(p_de[2]);
      len2 <= p_ee[0][LW-1:0] + p_ee[1][LW-1:0] + p_ee[2][LW-1:0];
      dd   <= p_dd[0][LW-1:0] + p_dd[1][LW-1:0] + p_dd[2][LW-1:0];
      ff   <= p_ff[0][LW-1:0] + p_ff[1][LW-1:0] + p_ff[2][LW-1:0];
    end
  end

  assign t_le0 = (t <= 0);
  assign t_geL = (t >= $signed({2'b00, len2}));
  assign tu    = t[LW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mid4  <= !t_le0 && !t_geL;
      base4 <= t_le0 ? dd : (t_geL ? ff : dd);
      len4  <= len2;
      a_hh  <= dd[LW-1:HW] * len2[LW-1:HW];
      a_hl  <= dd[LW-1:HW] * len2[HW-1:0];
      a_lh  <= dd[HW-1:0] * len2[LW-1:HW];
      a_ll  <= dd[HW-1:0] * len2[HW-1:0];
      t_hh  <= tu[LW-1:HW] * tu[LW-1:HW];
      t_hl  <= tu[LW-1:HW] * tu[HW-1:0];
      t_ll  <= tu[HW-1:0] * tu[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid5   <= mid4;
      base5  <= base4;
      len5   <= len4;
      prod_a <= (NW'(a_hh) << (2 * HW)) + ((NW'(a_hl) + NW'(a_lh)) << HW) + NW'(a_ll);
      prod_t <= (NW'(t_hh) << (2 * HW)) + (NW'(t_hl) << (HW + 1)) + NW'(t_ll);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.num <= mid5 ? prod_a - prod_t : NW'(base5);
      dout.den <= mid5 ? len5 : LW'(1);
    end
  end

  assign out_valid = v6;

endmodule

// ===== sv/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per stage, for num * 2^16 / den.
// ----------------------------------------------------------------------------
module psd_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  psd_pkg::div_in_t        din,
  output logic                    out_valid,
  output logic [psd_pkg::QW-1:0]  quot
);

  localparam int LW = psd_pkg::LW;
  localparam int QW = psd_pkg::QW;
  localparam int FB = psd_pkg::FB;

  logic          v    [QW+1];
  logic [LW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [LW-1:0] den  [QW+1];
  logic [QW-1:0] q    [QW+1];

  assign v[0]   = in_valid;
  assign rem[0] = din.num[2*LW-1:LW];
  assign low[0] = {din.num[LW-1:0], {FB{1'b0}}};
  assign den[0] = din.den;
  assign q[0]   = '0;

  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic [LW:0] trial;
    logic [LW:0] diff;

    assign trial = {rem[gi], low[gi][QW-1]};
    assign diff  = trial - {1'b0, den[gi]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[gi+1] <= 1'b0;
      end else if (en) begin
        v[gi+1] <= v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[gi+1] <= den[gi];
        low[gi+1] <= {low[gi][QW-2:0], 1'b0};
        if (!diff[LW]) begin
          rem[gi+1] <= diff[LW-1:0];
          q[gi+1]   <= {q[gi][QW-2:0], 1'b1};
        end else begin
          rem[gi+1] <= trial[LW-1:0];
          q[gi+1]   <= {q[gi][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];

endmodule

// ===== sv/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [psd_pkg::QW-1:0]  x_in,
  output logic                    out_valid,
  output logic [psd_pkg::RW-1:0]  root_out
);

  localparam int QW = psd_pkg::QW;
  localparam int RW = psd_pkg::RW;

  logic          v    [RW+1];
  logic [RW:0]   rem  [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [QW-1:0] x    [RW+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign x[0]    = x_in;

  for (genvar gi = 0; gi < RW; gi++) begin : g_stage
    logic [RW+1:0] r4;
    logic [RW+1:0] trial;
    logic [RW+2:0] diff;

    assign r4    = {rem[gi][RW-1:0], x[gi][QW-1:QW-2]};
    assign trial = {root[gi], 2'b01};
    assign diff  = {1'b0, r4} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[gi+1] <= 1'b0;
      end else if (en) begin
        v[gi+1] <= v[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[gi+1] <= {x[gi][QW-3:0], 2'b00};
        if (!diff[RW+2]) begin
          rem[gi+1]  <= diff[RW:0];
          root[gi+1] <= {root[gi][RW-2:0], 1'b1};
        end else begin
          rem[gi+1]  <= r4[RW:0];
          root[gi+1] <= {root[gi][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[RW];
  assign root_out  = root[RW];

endmodule

// ===== sv/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a configured 3-D segment, in Q8 fixed point.
// ----------------------------------------------------------------------------
// One query is taken every cycle while the skid register is empty; each
// passes 6 geometry stages, a 50-stage divider and a 25-stage root (one
// bit per stage in the last two). A one-entry skid register at the output
// catches an untaken result; while it holds one, intake and the pipeline
// stop until it is taken. The user writes endpoints through the register
// port only while no query is in flight; the block does not enforce it.
module point_segment_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] query_x,
  input  logic signed [15:0] query_y,
  input  logic signed [15:0] query_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [24:0]        distance_q8
);

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_END_X   = 3'd3;
  localparam logic [2:0] REG_END_Y   = 3'd4;
  localparam logic [2:0] REG_END_Z   = 3'd5;
  localparam int CNT_W = $clog2(psd_pkg::DEPTH + 2);

  logic signed [15:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic en;
  logic front_v, div_v, pipe_v, skid_v;
  psd_pkg::div_in_t div_in;
  logic [psd_pkg::QW-1:0] quot;
  logic [psd_pkg::RW-1:0] pipe_d, skid_d;
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      start_z <= '0;
      end_x   <= '0;
      end_y   <= '0;
      end_z   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_START_Z: start_z <= cfg_data;
        REG_END_X:   end_x   <= cfg_data;
        REG_END_Y:   end_y   <= cfg_data;
        REG_END_Z:   end_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v;
  assign in_ready = en;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .px        (query_x),
    .py        (query_y),
    .pz        (query_z),
    .ax        (start_x),
    .ay        (start_y),
    .az        (start_z),
    .bx        (end_x),
    .by        (end_y),
    .bz        (end_z),
    .out_valid (front_v),
    .dout      (div_in)
  );

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_v),
    .din       (div_in),
    .out_valid (div_v),
    .quot      (quot)
  );

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_v),
    .x_in      (quot),
    .out_valid (pipe_v),
    .root_out  (pipe_d)
  );

  // skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (!skid_v && pipe_v && !out_ready) begin
      skid_v <= 1'b1;
    end else if (skid_v && out_ready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid_d <= pipe_d;
    end
  end

  assign out_valid   = skid_v || pipe_v;
  assign distance_q8 = skid_v ? skid_d : pipe_d;

  // transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_valid && in_ready)
                           - CNT_W'(out_valid && out_ready);
    end
  end

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(pipe_v && !out_ready))
    else $error("skid filled without a stalled result");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(psd_pkg::DEPTH + 1))
    else $error("more transactions in flight than pipeline holds");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !out_valid)
    else $error("result without a pending transaction");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Point to segment distance: queries against several configured segments are
// streamed in bursts, each result is checked in order against a predicted
// distance computed with exact integer arithmetic.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } query_t;

  localparam int IDX_START_X = 0;
  localparam int IDX_START_Y = 1;
  localparam int IDX_START_Z = 2;
  localparam int IDX_END_X   = 3;
  localparam int IDX_END_Y   = 4;
  localparam int IDX_END_Z   = 5;
  localparam int IDX_UNUSED  = 6;
  localparam int LATENCY     = 90;
  localparam int LIMIT       = 400000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] query_x;
  logic signed [15:0] query_y;
  logic signed [15:0] query_z;
  logic               out_valid;
  logic               out_ready;
  logic [24:0]        distance_q8;

  point_segment_distance i_dut (.*);

  logic signed [15:0] seg_a [3];
  logic signed [15:0] seg_b [3];
  query_t             pending_queries [$];
  logic [24:0]        expected_distances [$];
  int                 n_errors = 0;
  int                 n_checked = 0;
  int                 n_sent = 0;
  int                 cycles;
  bit                 hold_sender;
  bit                 long_stall;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [24:0] segment_distance(query_t p);
    longint dx, dy, dz, ex, ey, ez, fx, fy, fz, dot, len2, dd;
    logic [127:0] num;
    logic [63:0]  q;
    dx = longint'(p.x) - seg_a[0];
    dy = longint'(p.y) - seg_a[1];
    dz = longint'(p.z) - seg_a[2];
    ex = longint'(seg_b[0]) - seg_a[0];
    ey = longint'(seg_b[1]) - seg_a[1];
    ez = longint'(seg_b[2]) - seg_a[2];
    fx = longint'(p.x) - seg_b[0];
    fy = longint'(p.y) - seg_b[1];
    fz = longint'(p.z) - seg_b[2];
    dot = dx * ex + dy * ey + dz * ez;
    len2 = ex * ex + ey * ey + ez * ez;
    dd = dx * dx + dy * dy + dz * dz;
    if (dot <= 0) begin
      q = 64'(dd) << 16;
    end else if (dot >= len2) begin
      q = 64'(fx * fx + fy * fy + fz * fz) << 16;
    end else begin
      num = 128'(dd) * 128'(len2) - 128'(dot) * 128'(dot);
      q = 64'((num << 16) / 128'(len2));
    end
    return 25'(int_sqrt(q));
  endfunction

  task automatic write_reg(int idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 3'(idx);
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == IDX_START_X) seg_a[0] = val;
    if (idx == IDX_START_Y) seg_a[1] = val;
    if (idx == IDX_START_Z) seg_a[2] = val;
    if (idx == IDX_END_X) seg_b[0] = val;
    if (idx == IDX_END_Y) seg_b[1] = val;
    if (idx == IDX_END_Z) seg_b[2] = val;
  endtask

  task automatic set_segment(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
    write_reg(IDX_START_X, ax);
    write_reg(IDX_START_Y, ay);
    write_reg(IDX_START_Z, az);
    write_reg(IDX_END_X, bx);
    write_reg(IDX_END_Y, by);
    write_reg(IDX_END_Z, bz);
  endtask

  task automatic drain;
    while (pending_queries.size() != 0 || expected_distances.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int spread);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic add_query(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    query_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_queries.push_back(p);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    static int burst = 0;
    static int gap = 0;
    if (rst) begin
      in_valid <= 1'b0;
      query_x  <= '0;
      query_y  <= '0;
      query_z  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_distances.push_back(segment_distance(pending_queries.pop_front()));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) gap--;
        if (hold_sender || gap > 0 || pending_queries.size() == 0 ||
            (in_valid && in_ready && pending_queries.size() < 2 &&
             pending_queries.size() == 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          query_x <= pending_queries[0].x;
          query_y <= pending_queries[0].y;
          query_z <= pending_queries[0].z;
          if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst--;
          end
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    static int stall_len = 0;
    static bit stall_done = 1'b0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_distances.size() == 0) begin
          $error("unexpected result distance_q8=%0d", distance_q8);
          n_errors++;
        end else begin
          if (distance_q8 !== expected_distances[0]) begin
            $error("distance_q8 expected %0d actual %0d", expected_distances[0],
                   distance_q8);
            n_errors++;
          end
          void'(expected_distances.pop_front());
          n_checked++;
        end
      end
      if (long_stall && !stall_done) begin
        stall_len = 300;
        stall_done = 1'b1;
      end
      if (stall_len > 0) begin
        stall_len--;
        out_ready <= 1'b0;
      end else begin
        case ((cycles / 200) % 3)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_sender = 0;
    long_stall = 0;
    for (int k = 0; k < 3; k++) begin
      seg_a[k] = '0;
      seg_b[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // degenerate segment at the origin after reset
    add_query(16'h0000, 16'h0000, 16'h0000);
    add_query(16'h7fff, 16'h7fff, 16'h7fff);
    add_query(16'h8000, 16'h8000, 16'h8000);
    drain();

    // longest possible segment, queries at its ends and beside it
    set_segment(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    write_reg(IDX_UNUSED, 16'hffff);
    add_query(16'h8000, 16'h8000, 16'h8000);
    add_query(16'h7fff, 16'h7fff, 16'h7fff);
    add_query(16'h8000, 16'h7fff, 16'h8000);
    add_query(16'h7fff, 16'h8000, 16'h7fff);
    add_query(16'h0000, 16'h0000, 16'h0000);
    add_query(16'h8000, 16'h7fff, 16'h7fff);
    drain();

    // z only segment, checks that z is not dropped
    set_segment(16'd10, 16'd20, 16'hffec, 16'd10, 16'd20, 16'd300);
    add_query(16'd10, 16'd20, 16'd100);
    add_query(16'd13, 16'd24, 16'd100);
    add_query(16'd10, 16'd20, 16'd400);
    add_query(16'd10, 16'd20, 16'hfc18);
    add_query(16'h7fff, 16'h8000, 16'd7);
    drain();

    // degenerate segment away from the origin
    set_segment(16'd5, 16'hfff0, 16'd77, 16'd5, 16'hfff0, 16'd77);
    add_query(16'h8000, 16'h7fff, 16'h0000);
    add_query(16'd5, 16'hfff0, 16'd77);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      int spread;
      spread = (ph % 3 == 0) ? 32767 : ((ph % 3 == 1) ? 200 : 4000);
      set_segment(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                  rand_coord(spread), rand_coord(spread), rand_coord(spread));
      if (ph == 5)
        for (int k = 0; k < 3; k++) write_reg(IDX_END_X + k, seg_a[k]);
      if (ph == 3) long_stall = 1;
      for (int n = 0; n < 100; n++)
        add_query(rand_coord(spread), rand_coord(spread), rand_coord(spread));
      if (ph == 7) begin
        while (pending_queries.size() > 50) @(posedge clk);
        hold_sender = 1;
        while (expected_distances.size() != 0) @(posedge clk);
        hold_sender = 0;
      end
      drain();
    end

    $display("covered %0d queries over 18 segment settings, %0d results checked",
             n_sent, n_checked);
    $display("including degenerate, extreme and axis aligned segments");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/psd_pkg.sv
sv/psd_front.sv
sv/psd_div.sv
sv/psd_sqrt.sv
sv/point_segment_distance.sv
verif/tb.sv
